// ----- rtl/core/lfu_pkg.sv -----
// lfu_pkg: shared types, constants and codes for the LFU cache directory.
// Depends on nothing; used by every file in rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
   localparam int ENTRIES   = 16;
   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);
   localparam int KEY_BITS  = 64;
   localparam int TIME_BITS = 48;
   localparam logic [31:0] BUDGET_RESET = 32'd104857600;
   localparam logic [31:0] TTL_RESET    = 32'd3600;

   typedef enum logic [3:0] {
      OP_PUT = 4'd0, OP_GET = 4'd1, OP_CONTAINS = 4'd2, OP_REMOVE = 4'd3,
      OP_PIN = 4'd4, OP_UNPIN = 4'd5, OP_EXPIRE = 4'd6, OP_CLEAR = 4'd7,
      OP_TICK = 4'd8
   } op_type;

   localparam logic [1:0] ST_OK = 2'd0, ST_ABSENT = 2'd1, ST_NOROOM = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_DECIDE, S_VSCAN, S_VDROP, S_FREE, S_WRITE,
      S_EXPIRE, S_DONE
   } state_type;

   // scan kinds the datapath can run
   typedef enum logic [1:0] {
      SCAN_KEY, SCAN_FREE, SCAN_VICTIM, SCAN_EXPIRE
   } scan_type;

   typedef struct packed {
      logic     load;       // capture request
      logic     scan_start; // clear scan index / found flag
      logic     scan_step;  // examine slot at index
      scan_type scan_kind;
      logic     drop_victim;
      logic     write_entry;
      logic     do_hit;     // get / remove / pin / unpin on found slot
      logic     do_clear;
      logic     do_tick;
      logic     set_norom;
      logic     set_absent;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   too_big;   // request bytes over budget
      logic   over;      // total + bytes over budget
      logic   scan_last; // index at last slot
      logic   found;     // scan hit
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/core/lfu_cache_with_byte_budget.sv -----
// lfu_cache_with_byte_budget: top level, APB register file and instances.
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath.
`timescale 1ns / 1ps
`default_nettype none
// LFU cache directory of 16 slots under a byte budget. A request is taken
// when start is high and busy low; one result follows, marked by rsp_valid
// for a single cycle in the first cycle after busy falls, and cannot be held
// off. Each request runs through the sequencer, which walks the slots one per
// cycle in each key lookup, victim search, free slot search or expiry sweep.
// Tick, clear, unknown codes and a put larger than the budget run no scan;
// expire runs the sweep; get, contains, remove, pin, unpin and a put over an
// existing key run a key lookup; a put of a new key into a free slot runs
// a key lookup, then a free slot search. Each eviction forced by the budget
// adds a victim search; the eviction for a full table adds a victim search
// and one more free slot search. Configuration (budget at 0x0, ttl at 0x4)
// is to be written over APB only while idle; the block does not enforce this.
module lfu_cache_with_byte_budget import lfu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_operation,
   input  wire logic [63:0] req_entry_key,
   input  wire logic [63:0] req_entry_handle,
   input  wire logic [31:0] req_entry_bytes,
   input  wire logic        req_pin_on_put,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_found_handle,
   output logic [31:0]      rsp_found_bytes,
   output logic [31:0]      rsp_bytes_in_use,
   output logic [4:0]       rsp_live_entries,
   output logic [4:0]       rsp_evicted_count,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   logic [31:0] budget_ff, ttl_ff;
   cmd_type cmd;
   sts_type sts;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         ttl_ff    <= TTL_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr == 3'd0) budget_ff <= pwdata;
         else if (paddr == 3'd4) ttl_ff <= pwdata;
      end
   end
   assign prdata = paddr == 3'd0 ? budget_ff : (paddr == 3'd4 ? ttl_ff : '0);

   lfu_ctrl u_ctrl (.clock, .reset, .start, .busy, .cmd, .sts);
   lfu_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req_operation, .req_entry_key,
      .req_entry_handle, .req_entry_bytes, .req_pin_on_put,
      .budget(budget_ff), .ttl(ttl_ff), .rsp_valid, .rsp_status,
      .rsp_found_handle, .rsp_found_bytes, .rsp_bytes_in_use,
      .rsp_live_entries, .rsp_evicted_count);
endmodule
`default_nettype wire

// ----- rtl/core/lfu_datapath.sv -----
// lfu_datapath: slot store, sequential scan unit, totals and result register.
// Depends on lfu_pkg; driven by lfu_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module lfu_datapath import lfu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic [3:0]  req_operation,
   input  wire logic [63:0] req_entry_key,
   input  wire logic [63:0] req_entry_handle,
   input  wire logic [31:0] req_entry_bytes,
   input  wire logic        req_pin_on_put,
   input  wire logic [31:0] budget,
   input  wire logic [31:0] ttl,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_found_handle,
   output logic [31:0]      rsp_found_bytes,
   output logic [31:0]      rsp_bytes_in_use,
   output logic [4:0]       rsp_live_entries,
   output logic [4:0]       rsp_evicted_count
);
   logic [ENTRIES-1:0]   valid_ff, valid_in, pinned_ff, pinned_in;
   logic [KEY_BITS-1:0]  key_ff     [ENTRIES];
   logic [63:0]          handle_ff  [ENTRIES];
   logic [31:0]          bytes_ff   [ENTRIES];
   logic [31:0]          hits_ff    [ENTRIES];
   logic [TIME_BITS-1:0] created_ff [ENTRIES];
   logic [TIME_BITS-1:0] last_ff    [ENTRIES];

   op_type          op_ff;
   logic [KEY_BITS-1:0] rkey_ff;
   logic [63:0]     rhandle_ff;
   logic [31:0]     rbytes_ff;
   logic            rpin_ff;
   logic [31:0]     total_ff, total_in;
   logic [TIME_BITS-1:0] now_ff;
   logic [IDX_BITS-1:0] idx_ff, match_ff;
   logic            found_ff;
   logic [CNT_BITS-1:0] evict_ff, live_sum;
   logic [1:0]      status_ff;
   logic [63:0]     fh_ff;
   logic [31:0]     fb_ff;

   logic [IDX_BITS-1:0] m;
   logic better, hit;
   logic [TIME_BITS-1:0] age;

   assign m   = match_ff;
   assign age = now_ff - created_ff[idx_ff];
   // victim ordering: hits, then last access, then key
   always_comb begin
      better = !found_ff || hits_ff[idx_ff] < hits_ff[m] ||
               (hits_ff[idx_ff] == hits_ff[m] && (last_ff[idx_ff] < last_ff[m] ||
               (last_ff[idx_ff] == last_ff[m] && key_ff[idx_ff] < key_ff[m])));
      unique case (cmd.scan_kind)
         SCAN_KEY:    hit = valid_ff[idx_ff] && key_ff[idx_ff] == rkey_ff;
         SCAN_FREE:   hit = !valid_ff[idx_ff];
         SCAN_VICTIM: hit = valid_ff[idx_ff] && !pinned_ff[idx_ff] && better;
         default:     hit = valid_ff[idx_ff] && !pinned_ff[idx_ff] &&
                            age > {16'd0, ttl};
      endcase
   end

   assign sts.op        = op_ff;
   assign sts.too_big   = rbytes_ff > budget;
   assign sts.over      = ({1'b0, total_ff} + {1'b0, rbytes_ff}) > {1'b0, budget};
   assign sts.scan_last = idx_ff == IDX_BITS'(ENTRIES - 1);
   assign sts.found     = found_ff;

   always_comb begin
      valid_in  = valid_ff;
      pinned_in = pinned_ff;
      total_in  = total_ff;
      if (cmd.scan_step && cmd.scan_kind == SCAN_EXPIRE && hit) begin
         valid_in[idx_ff] = 1'b0;
         total_in = total_ff - bytes_ff[idx_ff];
      end
      if (cmd.drop_victim) begin
         valid_in[m] = 1'b0;
         total_in = total_ff - bytes_ff[m];
      end
      if (cmd.do_hit) begin
         unique case (op_ff)
            OP_REMOVE: begin
               valid_in[m] = 1'b0;
               total_in = total_ff - bytes_ff[m];
            end
            OP_PIN:   pinned_in[m] = 1'b1;
            OP_UNPIN: pinned_in[m] = 1'b0;
            default:  ;
         endcase
      end
      if (cmd.write_entry) begin
         valid_in[m]  = 1'b1;
         pinned_in[m] = rpin_ff;
         // overwrite in place gives back the old size first
         total_in = (found_ff && valid_ff[m] && key_ff[m] == rkey_ff ?
                     total_ff - bytes_ff[m] : total_ff) + rbytes_ff;
      end
      if (cmd.do_clear) begin
         valid_in = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op_type'(req_operation);
         rkey_ff    <= req_entry_key[KEY_BITS-1:0];
         rhandle_ff <= req_entry_handle;
         rbytes_ff  <= req_entry_bytes;
         rpin_ff    <= req_pin_on_put;
         status_ff  <= ST_OK;
         fh_ff      <= '0;
         fb_ff      <= '0;
      end
      if (cmd.set_norom)  status_ff <= ST_NOROOM;
      if (cmd.set_absent) status_ff <= ST_ABSENT;
      if (cmd.scan_start) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (hit && cmd.scan_kind != SCAN_EXPIRE &&
             !(found_ff && cmd.scan_kind != SCAN_VICTIM)) begin
            found_ff <= 1'b1;
            match_ff <= idx_ff;
         end
      end
      if (cmd.write_entry) begin
         key_ff[m]     <= rkey_ff;
         handle_ff[m]  <= rhandle_ff;
         bytes_ff[m]   <= rbytes_ff;
         hits_ff[m]    <= '0;
         created_ff[m] <= now_ff;
         last_ff[m]    <= now_ff;
      end
      if (cmd.do_hit && op_ff == OP_GET) begin
         if (hits_ff[m] != '1) hits_ff[m] <= hits_ff[m] + 1'b1;
         last_ff[m] <= now_ff;
         fh_ff <= handle_ff[m];
         fb_ff <= bytes_ff[m];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         total_ff  <= '0;
         now_ff    <= '0;
         evict_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         total_ff  <= total_in;
         rsp_valid <= cmd.emit;
         if (cmd.do_tick) now_ff <= now_ff + 1'b1;
         if (cmd.load) evict_ff <= '0;
         else if (cmd.drop_victim ||
                  (cmd.scan_step && cmd.scan_kind == SCAN_EXPIRE && hit))
            evict_ff <= evict_ff + 1'b1;
      end
   end
   always_ff @(posedge clock) pinned_ff <= pinned_in;

   always_comb begin
      live_sum = '0;
      for (int i = 0; i < ENTRIES; i++) live_sum = live_sum + CNT_BITS'(valid_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status        <= status_ff;
         rsp_found_handle  <= fh_ff;
         rsp_found_bytes   <= fb_ff;
         rsp_bytes_in_use  <= total_ff;
         rsp_live_entries  <= 5'(live_sum);
         rsp_evicted_count <= 5'(evict_ff);
      end
   end

`ifndef ASSERT_OFF
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.do_clear |=> valid_ff == '0 && total_ff == '0) else $error("clear");
   a_drop: assert property (@(posedge clock) disable iff (reset)
      cmd.drop_victim |-> found_ff && valid_ff[m]) else $error("victim");
   a_wr: assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry |=> valid_ff[$past(m)]) else $error("write");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/lfu_ctrl.sv -----
// lfu_ctrl: sequencer for one request (scans, evictions, write, response).
// Depends on lfu_pkg; commands lfu_datapath.
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl import lfu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd,
   input  wire sts_type sts
);
   state_type state_ff, state_in;
   logic      evicted_once_ff, evicted_once_in; // free-slot search phase entered

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         evicted_once_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         evicted_once_ff <= evicted_once_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      evicted_once_in = evicted_once_ff;
      cmd = '0;
      cmd.scan_kind = SCAN_KEY;
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd.load = 1'b1;
            cmd.scan_start = 1'b1;
            evicted_once_in = 1'b0;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.scan_start = 1'b1;
            unique case (sts.op)
               OP_PUT: begin
                  if (sts.too_big) begin
                     cmd.set_norom = 1'b1;
                     state_in = S_DONE;
                  end else if (sts.over) state_in = S_VSCAN;
                  else state_in = S_FIND;
               end
               OP_GET, OP_CONTAINS, OP_REMOVE, OP_PIN, OP_UNPIN: state_in = S_FIND;
               OP_EXPIRE: state_in = S_EXPIRE;
               OP_CLEAR: begin
                  cmd.do_clear = 1'b1;
                  state_in = S_DONE;
               end
               OP_TICK: begin
                  cmd.do_tick = 1'b1;
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_VSCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_kind = SCAN_VICTIM;
            if (sts.scan_last) state_in = S_VDROP;
         end
         S_VDROP: begin
            cmd.scan_start = 1'b1;
            if (!sts.found) begin
               cmd.set_norom = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.drop_victim = 1'b1;
               // full-table eviction goes straight back to the free search
               state_in = evicted_once_ff ? S_FREE : S_DECIDE;
            end
         end
         S_FIND: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_WRITE;
         end
         S_FREE: begin
            cmd.scan_step = 1'b1;
            cmd.scan_kind = SCAN_FREE;
            if (sts.scan_last) state_in = S_WRITE;
         end
         S_WRITE: begin
            // key scan or free scan result is in found/match
            if (sts.op == OP_PUT) begin
               if (sts.found) begin
                  cmd.write_entry = 1'b1;
                  state_in = S_DONE;
               end else if (!evicted_once_ff && evicted_once_in == 1'b0 &&
                            state_ff == S_WRITE && !cmd.scan_start) begin
                  cmd.scan_start = 1'b1;
                  state_in = S_FREE;
                  evicted_once_in = 1'b1; // marks free-scan phase
               end else begin
                  cmd.set_norom = 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               if (!sts.found) cmd.set_absent = 1'b1;
               else if (sts.op != OP_CONTAINS) cmd.do_hit = 1'b1;
               state_in = S_DONE;
            end
         end
         S_EXPIRE: begin
            cmd.scan_step = 1'b1;
            cmd.scan_kind = SCAN_EXPIRE;
            if (sts.scan_last) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // free scan found nothing: evict one, then rescan free slots once
      if (state_ff == S_WRITE && sts.op == OP_PUT && !sts.found && evicted_once_ff) begin
         cmd.set_norom = 1'b0;
         cmd.scan_start = 1'b1;
         if (!cmd.drop_victim) state_in = S_VSCAN;
         evicted_once_in = 1'b1;
      end
   end

`ifndef ASSERT_OFF
   a_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_IDLE) else $error("emit");
   a_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy) else $error("load");
   a_one: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_entry, cmd.drop_victim, cmd.do_clear})) else $error("excl");
`endif
endmodule
`default_nettype wire

// ----- verif/lfu_cache_checker.sv -----
// lfu_cache_checker: watches the request, result and APB ports of the cache,
// predicts every result and compares it field by field. Depends on lfu_pkg.
`timescale 1ns / 1ps
module lfu_cache_checker import lfu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [3:0]  req_operation,
   input  logic [63:0] req_entry_key,
   input  logic [63:0] req_entry_handle,
   input  logic [31:0] req_entry_bytes,
   input  logic        req_pin_on_put,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [63:0] rsp_found_handle,
   input  logic [31:0] rsp_found_bytes,
   input  logic [31:0] rsp_bytes_in_use,
   input  logic [4:0]  rsp_live_entries,
   input  logic [4:0]  rsp_evicted_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          outstanding,
   output int          checked
);
   localparam logic [2:0] ADDR_BUDGET = 3'h0, ADDR_TTL = 3'h4;
   localparam int PEND_DEPTH = 4;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] handle;
      logic [31:0] fbytes;
      logic [31:0] in_use;
      logic [4:0]  live;
      logic [4:0]  evicted;
   } outcome_t;

   // predicted results waiting for the block, oldest at head_ptr
   outcome_t pending[PEND_DEPTH];
   int       head_ptr, tail_ptr;

   logic [31:0] budget, ttl, used_bytes;
   logic [47:0] clock_now;
   bit          live_tab[ENTRIES];
   bit          pin_tab[ENTRIES];
   logic [63:0] key_tab[ENTRIES];
   logic [63:0] handle_tab[ENTRIES];
   logic [31:0] size_tab[ENTRIES];
   logic [31:0] hit_tab[ENTRIES];
   logic [47:0] born_tab[ENTRIES];
   logic [47:0] seen_tab[ENTRIES];

   function automatic int slot_of(logic [63:0] k);
      for (int i = 0; i < ENTRIES; i++)
         if (live_tab[i] && key_tab[i] == k) return i;
      return -1;
   endfunction

   function automatic int vacant_slot();
      for (int i = 0; i < ENTRIES; i++)
         if (!live_tab[i]) return i;
      return -1;
   endfunction

   function automatic void drop(int i);
      used_bytes -= size_tab[i];
      live_tab[i] = 0;
   endfunction

   // least hits, then oldest access, then smallest key; pinned entries are safe
   function automatic bit evict_one();
      int v = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!live_tab[i] || pin_tab[i]) continue;
         if (v < 0 || hit_tab[i] < hit_tab[v] ||
             (hit_tab[i] == hit_tab[v] &&
              (seen_tab[i] < seen_tab[v] ||
               (seen_tab[i] == seen_tab[v] && key_tab[i] < key_tab[v]))))
            v = i;
      end
      if (v < 0) return 0;
      drop(v);
      return 1;
   endfunction

   function automatic bit over_budget(logic [31:0] b);
      return (33'(used_bytes) + 33'(b)) > 33'(budget);
   endfunction

   function automatic outcome_t cache_step(logic [3:0] op, logic [63:0] k,
                                           logic [63:0] h, logic [31:0] b, bit pin);
      outcome_t r;
      int s;
      logic [47:0] age;
      r = '{ST_OK, 64'd0, 32'd0, 32'd0, 5'd0, 5'd0};
      case (op)
         OP_PUT: begin
            if (b > budget) begin
               r.status = ST_NOROOM;
            end else begin
               while (over_budget(b)) begin
                  if (!evict_one()) break;
                  r.evicted++;
               end
               if (over_budget(b)) r.status = ST_NOROOM;
               else begin
                  s = slot_of(k);
                  if (s < 0) begin
                     s = vacant_slot();
                     if (s < 0) begin
                        if (evict_one()) begin
                           r.evicted++;
                           s = vacant_slot();
                        end
                     end
                  end else begin
                     used_bytes -= size_tab[s];
                  end
                  if (s < 0) r.status = ST_NOROOM;
                  else begin
                     live_tab[s] = 1; key_tab[s] = k; handle_tab[s] = h;
                     size_tab[s] = b; hit_tab[s] = 0; born_tab[s] = clock_now;
                     seen_tab[s] = clock_now; pin_tab[s] = pin;
                     used_bytes += b;
                  end
               end
            end
         end
         OP_GET: begin
            s = slot_of(k);
            if (s < 0) r.status = ST_ABSENT;
            else begin
               if (hit_tab[s] != 32'hFFFF_FFFF) hit_tab[s]++;
               seen_tab[s] = clock_now;
               r.handle = handle_tab[s];
               r.fbytes = size_tab[s];
            end
         end
         OP_CONTAINS: if (slot_of(k) < 0) r.status = ST_ABSENT;
         OP_REMOVE: begin
            s = slot_of(k);
            if (s < 0) r.status = ST_ABSENT; else drop(s);
         end
         OP_PIN, OP_UNPIN: begin
            s = slot_of(k);
            if (s < 0) r.status = ST_ABSENT; else pin_tab[s] = (op == OP_PIN);
         end
         OP_EXPIRE: begin
            for (int i = 0; i < ENTRIES; i++) begin
               age = clock_now - born_tab[i];   // modulo 2^48
               if (live_tab[i] && !pin_tab[i] && age > {16'd0, ttl}) begin
                  drop(i);
                  r.evicted++;
               end
            end
         end
         OP_CLEAR: begin
            foreach (live_tab[i]) live_tab[i] = 0;
            used_bytes = 0;
         end
         OP_TICK: clock_now = clock_now + 48'd1;
         default: ;                             // unknown codes do nothing
      endcase
      foreach (live_tab[i]) if (live_tab[i]) r.live++;
      r.in_use = used_bytes;
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_t e;
      if (reset) begin
         budget = BUDGET_RESET;
         ttl = TTL_RESET;
         used_bytes = 0;
         clock_now = 0;
         foreach (live_tab[i]) live_tab[i] = 0;
         head_ptr = 0;
         tail_ptr = 0;
         fail_count = 0;
         checked = 0;
      end else begin
         if (rsp_valid) begin
            if (tail_ptr == head_ptr) begin
               $error("result with nothing expected");
               fail_count++;
            end else begin
               e = pending[head_ptr % PEND_DEPTH];
               head_ptr++;
               checked++;
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_found_handle !== e.handle) begin
                  $error("found_handle: expected %h, got %h", e.handle, rsp_found_handle);
                  fail_count++;
               end
               if (rsp_found_bytes !== e.fbytes) begin
                  $error("found_bytes: expected %0d, got %0d", e.fbytes, rsp_found_bytes);
                  fail_count++;
               end
               if (rsp_bytes_in_use !== e.in_use) begin
                  $error("bytes_in_use: expected %0d, got %0d", e.in_use, rsp_bytes_in_use);
                  fail_count++;
               end
               if (rsp_live_entries !== e.live) begin
                  $error("live_entries: expected %0d, got %0d", e.live, rsp_live_entries);
                  fail_count++;
               end
               if (rsp_evicted_count !== e.evicted) begin
                  $error("evicted_count: expected %0d, got %0d", e.evicted,
                         rsp_evicted_count);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            if (tail_ptr - head_ptr >= PEND_DEPTH) begin
               $error("more requests in flight than the block can hold");
               fail_count++;
            end else begin
               pending[tail_ptr % PEND_DEPTH] = cache_step(req_operation,
                  req_entry_key, req_entry_handle, req_entry_bytes, req_pin_on_put);
               tail_ptr++;
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_BUDGET) budget = pwdata;
            else if (paddr == ADDR_TTL) ttl = pwdata;
         end
      end
      outstanding = tail_ptr - head_ptr;
   end
endmodule

// ----- verif/lfu_cache_with_byte_budget_tb.sv -----
// lfu_cache_with_byte_budget_tb: stimulus and verdict for the LFU cache.
// Depends on lfu_pkg, the block and lfu_cache_checker.
`timescale 1ns / 1ps
module lfu_cache_with_byte_budget_tb;
   import lfu_pkg::*;

   localparam int  RANDOM_PER_PHASE = 100;
   localparam int  CYCLE_LIMIT      = 1_000_000;
   localparam logic [2:0] ADDR_BUDGET = 3'h0, ADDR_TTL = 3'h4;
   localparam logic [3:0] OP_UNKNOWN_LO = 4'd9, OP_UNKNOWN_HI = 4'd15;

   logic        clock = 0, reset = 1, start = 0;
   logic        busy, rsp_valid, pready;
   logic [3:0]  req_operation = '0;
   logic [63:0] req_entry_key = '0, req_entry_handle = '0;
   logic [31:0] req_entry_bytes = '0;
   logic        req_pin_on_put = 0;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_found_handle;
   logic [31:0] rsp_found_bytes, rsp_bytes_in_use, prdata;
   logic [4:0]  rsp_live_entries, rsp_evicted_count;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   int          fail_count, outstanding, checked;
   int          cycles = 0;
   int          requests_sent = 0;
   logic [63:0] key_pool[20];

   always #2 clock = ~clock;

   lfu_cache_with_byte_budget DUT (.*);

   lfu_cache_checker u_checker (.*);

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("lfu_cache_with_byte_budget_tb: errors");
         $finish;
      end
   end

   // one request: fields change at the falling edge; start stays high across
   // back-to-back requests and is only lowered when a gap follows. busy is
   // looked at on the falling edge, so the next rising edge is the accepting one.
   task automatic send_request(logic [3:0] op, logic [63:0] k, logic [63:0] h,
                               logic [31:0] b, bit pin, int gap);
      @(negedge clock);
      req_operation = op; req_entry_key = k; req_entry_handle = h;
      req_entry_bytes = b; req_pin_on_put = pin; start = 1;
      while (busy) @(negedge clock);
      @(posedge clock);
      requests_sent++;
      if (gap > 0) begin
         @(negedge clock);
         start = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // mostly short gaps, a few long ones, plenty of back-to-back requests
   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   // registers only change with nothing in flight; start is dropped first so
   // the last request is not taken a second time
   task automatic wait_idle();
      @(negedge clock);
      start = 0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] a, logic [31:0] d);
      @(negedge clock);
      psel = 1; pwrite = 1; penable = 0; paddr = a; pwdata = d;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   function automatic logic [63:0] pick_key();
      if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 19)];
      return {$urandom, $urandom};
   endfunction

   // sizes mostly small so that low budgets force evictions
   function automatic logic [31:0] pick_bytes();
      int r = $urandom_range(0, 99);
      if (r < 5) return 32'd0;
      if (r < 70) return $urandom_range(1, 400);
      if (r < 88) return $urandom_range(1, 5000);
      if (r < 92) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic logic [3:0] pick_op();
      int r = $urandom_range(0, 99);
      if (r < 30) return OP_PUT;
      if (r < 50) return OP_GET;
      if (r < 57) return OP_CONTAINS;
      if (r < 64) return OP_REMOVE;
      if (r < 70) return OP_PIN;
      if (r < 76) return OP_UNPIN;
      if (r < 83) return OP_EXPIRE;
      if (r < 85) return OP_CLEAR;
      if (r < 96) return OP_TICK;
      return 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
   endfunction

   initial begin
      logic [31:0] budgets[6];
      logic [31:0] ttls[6];
      logic [63:0] kmax;
      budgets = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd300, 32'd5000, BUDGET_RESET};
      ttls    = '{32'd5, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd20, TTL_RESET};
      kmax = 64'hFFFF_FFFF_FFFF_FFFF;
      key_pool[0] = 64'd0;
      key_pool[1] = kmax;
      for (int i = 2; i < 20; i++) key_pool[i] = {$urandom, $urandom};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: field extremes, every operation, the named corner cases,
      // all under the reset budget and ttl
      send_request(OP_GET, 64'd0, 64'd0, 32'd0, 0, 0);          // absent key
      send_request(OP_PUT, 64'd0, kmax, 32'd0, 1, 0);           // zero bytes, pinned
      send_request(OP_PUT, kmax, 64'h0123_4567_89AB_CDEF, 32'd1000, 0, 1);
      send_request(OP_PUT, 64'd5, 64'd1, 32'hFFFF_FFFF, 0, 0);  // over budget
      send_request(OP_GET, kmax, 64'd0, 32'd0, 0, 0);
      send_request(OP_GET, 64'd0, 64'd0, 32'd0, 0, 2);
      send_request(OP_CONTAINS, kmax, 64'd0, 32'd0, 0, 0);
      send_request(OP_CONTAINS, 64'd7, 64'd0, 32'd0, 0, 0);
      send_request(OP_PUT, kmax, 64'd9, 32'd200, 0, 0);         // overwrite in place
      send_request(OP_UNPIN, 64'd0, 64'd0, 32'd0, 0, 0);
      send_request(OP_PIN, kmax, 64'd0, 32'd0, 0, 0);
      send_request(OP_PIN, 64'd3, 64'd0, 32'd0, 0, 0);          // absent
      send_request(OP_UNPIN, 64'd3, 64'd0, 32'd0, 0, 0);        // absent
      send_request(OP_TICK, 64'd0, 64'd0, 32'd0, 0, 0);
      send_request(OP_EXPIRE, 64'd0, 64'd0, 32'd0, 0, 0);
      send_request(OP_REMOVE, 64'd0, 64'd0, 32'd0, 0, 0);
      send_request(OP_REMOVE, 64'd0, 64'd0, 32'd0, 0, 0);       // already gone
      send_request(OP_UNKNOWN_HI, kmax, kmax, 32'hFFFF_FFFF, 1, 0);
      send_request(OP_CLEAR, 64'd0, 64'd0, 32'd0, 0, 3);
      for (int i = 0; i < 17; i++)                              // fill, then full table
         send_request(OP_PUT, 64'(i + 100), 64'(i), 32'd10, i[0], 0);

      // random phases, each under its own budget and ttl; the low budget that
      // follows a large one leaves use over budget until a put evicts
      foreach (budgets[p]) begin
         wait_idle();
         csr_write(ADDR_BUDGET, budgets[p]);
         csr_write(ADDR_TTL, ttls[p]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_request(pick_op(), pick_key(), {$urandom, $urandom}, pick_bytes(),
                         $urandom_range(0, 3) == 0, pick_gap());
      end

      @(negedge clock);
      start = 0;
      wait_idle();
      repeat (400) @(posedge clock);   // any stray result would show here

      $display("%0d requests over %0d budget/ttl settings, %0d results checked",
               requests_sent, $size(budgets) + 1, checked);
      if (fail_count == 0)
         $display("lfu_cache_with_byte_budget_tb: clean");
      else
         $display("lfu_cache_with_byte_budget_tb: errors");
      $finish;
   end
endmodule
